>>> rtl/core/csua_pkg.sv
// ----------------------------------------------------------------------------
// csua_pkg: shared types and constants of the C integer ALU
// Opcodes, error codes, operation classes and the work item that travels
// from the classifying front end to the execution back end.
// ----------------------------------------------------------------------------
package csua_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int SHIFT_W    = $clog2(DATA_WIDTH);
    localparam int HALF_W     = (DATA_WIDTH + 1) / 2;
    localparam int PORT_W     = 64;

    typedef enum logic [4:0] {
        OP_MUL    = 5'd0,
        OP_DIV    = 5'd1,
        OP_MOD    = 5'd2,
        OP_ADD    = 5'd3,
        OP_SUB    = 5'd4,
        OP_SHL    = 5'd5,
        OP_SHR    = 5'd6,
        OP_LT     = 5'd7,
        OP_LE     = 5'd8,
        OP_GT     = 5'd9,
        OP_GE     = 5'd10,
        OP_EQ     = 5'd11,
        OP_NE     = 5'd12,
        OP_AND    = 5'd13,
        OP_XOR    = 5'd14,
        OP_OR     = 5'd15,
        OP_LAND   = 5'd16,
        OP_LOR    = 5'd17,
        OP_COMMA  = 5'd18,
        OP_LNOT   = 5'd19,
        OP_NOT    = 5'd20,
        OP_PLUS   = 5'd21,
        OP_NEG    = 5'd22
    } t_opcode;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_DIV_OVF  = 2'd2,
        ERR_MOD_ZERO = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0,
        CLS_MUL    = 2'd1,
        CLS_DIV    = 2'd2,
        CLS_MOD    = 2'd3
    } t_class;

    typedef struct packed {
        t_class                  cls;
        logic                    rs;
        t_err                    err;
        logic                    neg;
        logic [DATA_WIDTH-1:0]   val;
        logic [DATA_WIDTH-1:0]   opa;
        logic [DATA_WIDTH-1:0]   opb;
    } t_work;

    typedef struct packed {
        t_class                  cls;
        logic                    rs;
        t_err                    err;
        logic                    neg;
        logic [DATA_WIDTH-1:0]   val;
        logic [DATA_WIDTH-1:0]   rem;
        logic [DATA_WIDTH-1:0]   quo;
        logic [DATA_WIDTH-1:0]   dvs;
    } t_stage;

endpackage

>>> rtl/core/csua_front.sv
// ----------------------------------------------------------------------------
// csua_front: operation decode and classification
// Takes one beat, finishes every simple operation and prepares
// magnitudes and sign fixups for the divider.
// ----------------------------------------------------------------------------
module csua_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [4:0]                          i_opcode,
    input  logic [csua_pkg::PORT_W-1:0]         i_operand_a,
    input  logic                                i_a_is_signed,
    input  logic [csua_pkg::PORT_W-1:0]         i_operand_b,
    input  logic                                i_b_is_signed,
    output logic                                o_work_valid,
    output csua_pkg::t_work                     o_work,
    input  logic                                i_work_take
);

    localparam int DW = csua_pkg::DATA_WIDTH;
    localparam int SW = csua_pkg::SHIFT_W;

    logic                 r_valid;
    csua_pkg::t_work      r_work;
    csua_pkg::t_work      n_work;
    logic                 accept;

    logic [DW-1:0] a, b, a_abs, b_abs, smin;
    logic          both, na, nb, oor, lt, gt;
    logic [SW-1:0] sh;

    assign accept       = i_valid && !o_stall;
    assign o_stall      = r_valid && !i_work_take;
    assign o_work_valid = r_valid;
    assign o_work       = r_work;

    always_comb begin
        a     = i_operand_a[DW-1:0];
        b     = i_operand_b[DW-1:0];
        both  = i_a_is_signed && i_b_is_signed;
        na    = a[DW-1];
        nb    = b[DW-1];
        a_abs = na ? (DW'(0) - a) : a;
        b_abs = nb ? (DW'(0) - b) : b;
        smin  = DW'(1) << (DW - 1);
        oor   = (i_b_is_signed && nb) || (b >= DW'(DW));
        sh    = b[SW-1:0];
        lt    = both ? ($signed(a) < $signed(b)) : (a < b);
        gt    = both ? ($signed(a) > $signed(b)) : (a > b);

        n_work     = '0;
        n_work.cls = csua_pkg::CLS_SIMPLE;
        n_work.err = csua_pkg::ERR_NONE;
        n_work.opa = a;
        n_work.opb = b;

        unique case (csua_pkg::t_opcode'(i_opcode))
            csua_pkg::OP_MUL: begin
                n_work.rs  = both;
                n_work.cls = csua_pkg::CLS_MUL;
            end
            csua_pkg::OP_DIV, csua_pkg::OP_MOD: begin
                n_work.rs = both;
                if (b == '0) begin
                    n_work.err = (i_opcode == csua_pkg::OP_DIV) ?
                                 csua_pkg::ERR_DIV_ZERO : csua_pkg::ERR_MOD_ZERO;
                end else if (both && a == smin && b == '1) begin
                    // Signed minimum by minus one: the quotient overflows,
                    // the remainder is simply zero.
                    if (i_opcode == csua_pkg::OP_DIV) begin
                        n_work.err = csua_pkg::ERR_DIV_OVF;
                    end
                end else begin
                    n_work.cls = (i_opcode == csua_pkg::OP_DIV) ?
                                 csua_pkg::CLS_DIV : csua_pkg::CLS_MOD;
                    if (both) begin
                        n_work.opa = a_abs;
                        n_work.opb = b_abs;
                        n_work.neg = (i_opcode == csua_pkg::OP_DIV) ? (na != nb) : na;
                    end
                end
            end
            csua_pkg::OP_ADD:  begin n_work.rs = both; n_work.val = a + b; end
            csua_pkg::OP_SUB:  begin n_work.rs = both; n_work.val = a - b; end
            csua_pkg::OP_AND:  begin n_work.rs = both; n_work.val = a & b; end
            csua_pkg::OP_XOR:  begin n_work.rs = both; n_work.val = a ^ b; end
            csua_pkg::OP_OR:   begin n_work.rs = both; n_work.val = a | b; end
            csua_pkg::OP_SHL: begin
                n_work.rs  = i_a_is_signed;
                n_work.val = oor ? '0 : (a << sh);
            end
            csua_pkg::OP_SHR: begin
                n_work.rs = i_a_is_signed;
                if (oor) begin
                    n_work.val = (i_a_is_signed && na) ? '1 : '0;
                end else if (i_a_is_signed) begin
                    n_work.val = DW'($signed(a) >>> sh);
                end else begin
                    n_work.val = a >> sh;
                end
            end
            csua_pkg::OP_LT:   begin n_work.rs = 1'b1; n_work.val = DW'(lt); end
            csua_pkg::OP_LE:   begin n_work.rs = 1'b1; n_work.val = DW'(!gt); end
            csua_pkg::OP_GT:   begin n_work.rs = 1'b1; n_work.val = DW'(gt); end
            csua_pkg::OP_GE:   begin n_work.rs = 1'b1; n_work.val = DW'(!lt); end
            csua_pkg::OP_EQ:   begin n_work.rs = 1'b1; n_work.val = DW'(a == b); end
            csua_pkg::OP_NE:   begin n_work.rs = 1'b1; n_work.val = DW'(a != b); end
            csua_pkg::OP_LAND: begin
                n_work.rs  = 1'b1;
                n_work.val = DW'(a != '0 && b != '0);
            end
            csua_pkg::OP_LOR: begin
                n_work.rs  = 1'b1;
                n_work.val = DW'(a != '0 || b != '0);
            end
            csua_pkg::OP_COMMA: begin n_work.rs = i_b_is_signed; n_work.val = b; end
            csua_pkg::OP_LNOT:  begin n_work.rs = 1'b1; n_work.val = DW'(a == '0); end
            csua_pkg::OP_NOT:   begin n_work.rs = i_a_is_signed; n_work.val = ~a; end
            csua_pkg::OP_PLUS:  begin n_work.rs = i_a_is_signed; n_work.val = a; end
            csua_pkg::OP_NEG: begin
                n_work.rs  = i_a_is_signed;
                n_work.val = DW'(0) - a;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_work_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

>>> rtl/core/csua_queue.sv
// ----------------------------------------------------------------------------
// csua_queue: two-entry work queue
// Decouples the front end from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
module csua_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csua_pkg::t_work   i_work,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output csua_pkg::t_work   o_work
);

    csua_pkg::t_work r_entry [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_work  = r_entry[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_work;
        end
    end

endmodule

>>> rtl/core/csua_back.sv
// ----------------------------------------------------------------------------
// csua_back: execution pipeline
// Two-stage split multiplier and a one-bit-per-stage restoring divider,
// with simple results riding along, followed by the output register.
// ----------------------------------------------------------------------------
module csua_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  csua_pkg::t_work               i_work,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [csua_pkg::PORT_W-1:0]   o_result_value,
    output logic                          o_result_is_signed,
    output logic [1:0]                    o_error_code
);

    localparam int DW = csua_pkg::DATA_WIDTH;
    localparam int HW = csua_pkg::HALF_W;
    localparam int XW = 2 * HW;

    function automatic csua_pkg::t_stage div_step(csua_pkg::t_stage s);
        csua_pkg::t_stage o;
        logic [DW:0]      part;
        logic [DW:0]      diff;
        o    = s;
        part = {s.rem, s.quo[DW-1]};
        diff = part - {1'b0, s.dvs};
        // The borrow bit tells whether the divisor fits into the partial remainder.
        if (!diff[DW]) begin
            o.rem = diff[DW-1:0];
            o.quo = {s.quo[DW-2:0], 1'b1};
        end else begin
            o.rem = part[DW-1:0];
            o.quo = {s.quo[DW-2:0], 1'b0};
        end
        return o;
    endfunction

    logic             en;
    logic             r_v [DW+1];
    csua_pkg::t_stage r_st [DW+1];
    csua_pkg::t_stage n_st [DW+1];
    logic [XW-1:0]    r_pll;
    logic [HW-1:0]    r_plh;
    logic [HW-1:0]    r_phl;
    logic [XW-1:0]    xa, xb;
    logic [DW-1:0]    mul_sum;

    logic             r_out_v;
    logic [DW-1:0]    r_out_val;
    logic             r_out_rs;
    csua_pkg::t_err   r_out_err;
    logic [DW-1:0]    n_out_val;

    assign en      = !(r_out_v && i_stall);
    assign o_pop   = en && !i_empty;
    assign xa      = XW'(r_st[0].quo);
    assign xb      = XW'(r_st[0].dvs);
    assign mul_sum = DW'(r_pll + {r_plh + r_phl, HW'(0)});

    always_comb begin
        n_st[0]     = '0;
        n_st[0].cls = i_work.cls;
        n_st[0].rs  = i_work.rs;
        n_st[0].err = i_work.err;
        n_st[0].neg = i_work.neg;
        n_st[0].val = i_work.val;
        n_st[0].quo = i_work.opa;
        n_st[0].dvs = i_work.opb;
    end

    for (genvar k = 1; k <= DW; k++) begin : g_stage
        always_comb begin
            n_st[k] = div_step(r_st[k-1]);
            if (k == 2 && r_st[1].cls == csua_pkg::CLS_MUL) begin
                n_st[k].val = mul_sum;
            end
        end
    end

    for (genvar k = 0; k <= DW; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en) begin
                r_v[k] <= (k == 0) ? !i_empty : r_v[(k == 0) ? 0 : k - 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Only the low DW bits of the product are kept, so the high-by-high
    // partial product is never needed.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pll <= XW'(xa[HW-1:0]) * XW'(xb[HW-1:0]);
            r_plh <= HW'(xa[HW-1:0] * xb[XW-1:HW]);
            r_phl <= HW'(xa[XW-1:HW] * xb[HW-1:0]);
        end
    end

    always_comb begin
        case (r_st[DW].cls)
            csua_pkg::CLS_DIV: n_out_val = r_st[DW].neg ? (DW'(0) - r_st[DW].quo) : r_st[DW].quo;
            csua_pkg::CLS_MOD: n_out_val = r_st[DW].neg ? (DW'(0) - r_st[DW].rem) : r_st[DW].rem;
            default:           n_out_val = r_st[DW].val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val <= n_out_val;
            r_out_rs  <= r_st[DW].rs;
            r_out_err <= r_st[DW].err;
        end
    end

    assign o_valid            = r_out_v;
    assign o_result_value     = csua_pkg::PORT_W'(r_out_val);
    assign o_result_is_signed = r_out_rs;
    assign o_error_code       = r_out_err;

endmodule

>>> rtl/core/c_signed_unsigned_integer_alu_core.sv
// ----------------------------------------------------------------------------
// c_signed_unsigned_integer_alu_core: C integer ALU with signed and unsigned
// operands
// Front end decodes and classifies, a short queue decouples it from the
// execution pipeline that holds the multiplier and divider.
// ----------------------------------------------------------------------------
// The block accepts one operation every cycle while o_stall is low and returns
// results in order. Every operation takes the same path: the decode register,
// the queue entry, and DATA_WIDTH + 1 pipeline stages set by the divider, which
// retires one quotient bit per stage, plus the output register. A stalled
// result beat freezes the whole execution pipeline. Results narrower than the
// port are zero-extended.
module c_signed_unsigned_integer_alu_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [4:0]                    i_opcode,
    input  logic [csua_pkg::PORT_W-1:0]   i_operand_a,
    input  logic                          i_a_is_signed,
    input  logic [csua_pkg::PORT_W-1:0]   i_operand_b,
    input  logic                          i_b_is_signed,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [csua_pkg::PORT_W-1:0]   o_result_value,
    output logic                          o_result_is_signed,
    output logic [1:0]                    o_error_code
);

    logic            f_valid;
    csua_pkg::t_work f_work;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    logic            push;
    csua_pkg::t_work q_work;

    assign push = f_valid && !q_full;

    csua_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_operand_a   (i_operand_a),
        .i_a_is_signed (i_a_is_signed),
        .i_operand_b   (i_operand_b),
        .i_b_is_signed (i_b_is_signed),
        .o_work_valid  (f_valid),
        .o_work        (f_work),
        .i_work_take   (push)
    );

    csua_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (f_work),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_work  (q_work)
    );

    csua_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (q_empty),
        .i_work             (q_work),
        .o_pop              (q_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_result_value     (o_result_value),
        .o_result_is_signed (o_result_is_signed),
        .o_error_code       (o_error_code)
    );

endmodule

>>> tb/tb_c_signed_unsigned_integer_alu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_signed_unsigned_integer_alu_core: self-checking bench for the C ALU
// A directed table of corner cases and then random operations are driven
// through the valid/stall input channel. An in-bench model of the C promotion
// and arithmetic rules predicts each result not typed into a directed row, and
// every output beat is compared field by field against the oldest expectation,
// under four phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_c_signed_unsigned_integer_alu_core;

    localparam int W        = csua_pkg::DATA_WIDTH;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = csua_pkg::DATA_WIDTH + 20;

    typedef logic [W-1:0] t_word;

    typedef struct {
        logic [4:0]       op;
        logic [63:0]      a;
        logic             as;
        logic [63:0]      b;
        logic             bs;
        logic             known;  // expected result typed into the row
        logic [63:0]      val;
        logic             rs;
        csua_pkg::t_err   err;
    } t_row;

    typedef struct {
        logic [63:0]      val;
        logic             rs;
        csua_pkg::t_err   err;
    } t_res;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_stall;
    logic [4:0]     i_opcode = '0;
    logic [63:0]    i_operand_a = '0;
    logic           i_a_is_signed = 1'b0;
    logic [63:0]    i_operand_b = '0;
    logic           i_b_is_signed = 1'b0;
    logic           o_valid;
    logic           i_stall = 1'b0;
    logic [63:0]    o_result_value;
    logic           o_result_is_signed;
    logic [1:0]     o_error_code;

    t_res   pending_results[$];
    int     n_errors = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    c_signed_unsigned_integer_alu_core DUT (.*);

    function automatic t_word neg_w(t_word x);
        return t_word'(0) - x;
    endfunction

    function automatic t_res alu_predict(logic [4:0] op, logic [63:0] a_in, logic as,
                                         logic [63:0] b_in, logic bs);
        t_res   r;
        t_word  a, b, ua, ub, q;
        t_word  smin;
        logic   both, na, nb, oor;
        a = a_in[W-1:0];
        b = b_in[W-1:0];
        smin = t_word'(1) << (W - 1);
        both = as & bs;
        na = a[W-1];
        nb = b[W-1];
        r.val = '0;
        r.rs = 1'b0;
        r.err = csua_pkg::ERR_NONE;
        q = '0;
        case (op)
            csua_pkg::OP_MUL, csua_pkg::OP_DIV, csua_pkg::OP_MOD, csua_pkg::OP_ADD,
            csua_pkg::OP_SUB, csua_pkg::OP_AND, csua_pkg::OP_XOR, csua_pkg::OP_OR: begin
                r.rs = both;
                case (op)
                    csua_pkg::OP_MUL: q = a * b;
                    csua_pkg::OP_ADD: q = a + b;
                    csua_pkg::OP_SUB: q = a - b;
                    csua_pkg::OP_AND: q = a & b;
                    csua_pkg::OP_XOR: q = a ^ b;
                    csua_pkg::OP_OR:  q = a | b;
                    default: begin
                        if (b == 0) begin
                            r.err = (op == csua_pkg::OP_DIV) ?
                                    csua_pkg::ERR_DIV_ZERO : csua_pkg::ERR_MOD_ZERO;
                        end else if (!both) begin
                            q = (op == csua_pkg::OP_DIV) ? a / b : a % b;
                        end else if (a == smin && b == '1) begin
                            if (op == csua_pkg::OP_DIV) r.err = csua_pkg::ERR_DIV_OVF;
                        end else begin
                            ua = na ? neg_w(a) : a;
                            ub = nb ? neg_w(b) : b;
                            if (op == csua_pkg::OP_DIV) begin
                                q = ua / ub;
                                if (na != nb) q = neg_w(q);
                            end else begin
                                q = ua % ub;
                                if (na) q = neg_w(q);
                            end
                        end
                    end
                endcase
            end
            csua_pkg::OP_SHL, csua_pkg::OP_SHR: begin
                r.rs = as;
                oor = (bs && nb) || (b >= W);
                if (oor) q = (op == csua_pkg::OP_SHR && as && na) ? '1 : '0;
                else if (op == csua_pkg::OP_SHL) q = a << b;
                else if (as) q = t_word'($signed(a) >>> b);
                else q = a >> b;
            end
            csua_pkg::OP_LT: begin
                r.rs = 1'b1;
                q = both ? ($signed(a) < $signed(b)) : (a < b);
            end
            csua_pkg::OP_LE: begin
                r.rs = 1'b1;
                q = both ? ($signed(a) <= $signed(b)) : (a <= b);
            end
            csua_pkg::OP_GT: begin
                r.rs = 1'b1;
                q = both ? ($signed(a) > $signed(b)) : (a > b);
            end
            csua_pkg::OP_GE: begin
                r.rs = 1'b1;
                q = both ? ($signed(a) >= $signed(b)) : (a >= b);
            end
            csua_pkg::OP_EQ:    begin r.rs = 1'b1; q = (a == b); end
            csua_pkg::OP_NE:    begin r.rs = 1'b1; q = (a != b); end
            csua_pkg::OP_LAND:  begin r.rs = 1'b1; q = (a != 0 && b != 0); end
            csua_pkg::OP_LOR:   begin r.rs = 1'b1; q = (a != 0 || b != 0); end
            csua_pkg::OP_COMMA: begin r.rs = bs; q = b; end
            csua_pkg::OP_LNOT:  begin r.rs = 1'b1; q = (a == 0); end
            csua_pkg::OP_NOT:   begin r.rs = as; q = ~a; end
            csua_pkg::OP_PLUS:  begin r.rs = as; q = a; end
            csua_pkg::OP_NEG:   begin r.rs = as; q = neg_w(a); end
            default: ;
        endcase
        if (r.err != csua_pkg::ERR_NONE) q = '0;
        r.val = 64'(q);
        return r;
    endfunction

    // Output side: stall at random and check every accepted beat.
    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: value %h", o_result_value);
                n_errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_result_value !== exp_res.val) begin
                    $error("result_value: expected %h, actual %h", exp_res.val,
                           o_result_value);
                    n_errors++;
                end
                if (o_result_is_signed !== exp_res.rs) begin
                    $error("result_is_signed: expected %b, actual %b", exp_res.rs,
                           o_result_is_signed);
                    n_errors++;
                end
                if (o_error_code !== exp_res.err) begin
                    $error("error_code: expected %0d, actual %0d", exp_res.err,
                           o_error_code);
                    n_errors++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb_c_signed_unsigned_integer_alu_core: done, errors");
            $finish;
        end
    end

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(7))
            0: v = '0;
            1: v = '1;
            2: v = 64'(1) << (W - 1);
            3: v = (64'(1) << (W - 1)) - 1;
            4: v = 64'($urandom_range(70));
            5: v = -64'($urandom_range(70));
            default: ;
        endcase
        return v;
    endfunction

    // Drives one beat and holds it until the block takes it.
    task automatic send_op(logic [4:0] op, logic [63:0] a, logic as,
                           logic [63:0] b, logic bs);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_operand_a <= a;
        i_a_is_signed <= as;
        i_operand_b <= b;
        i_b_is_signed <= bs;
        pending_results.push_back(alu_predict(op, a, as, b, bs));
        do @(posedge i_clk); while (o_stall);
    endtask

    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] SMAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

    t_row directed_rows[] = '{
        '{csua_pkg::OP_DIV,   64'd5,  1, 64'd0,  1, 1, 64'd0, 1, csua_pkg::ERR_DIV_ZERO},
        '{csua_pkg::OP_MOD,   64'd5,  0, 64'd0,  1, 1, 64'd0, 0, csua_pkg::ERR_MOD_ZERO},
        '{csua_pkg::OP_DIV,   SMIN,   1, ONES,   1, 1, 64'd0, 1, csua_pkg::ERR_DIV_OVF},
        '{csua_pkg::OP_MOD,   SMIN,   1, ONES,   1, 1, 64'd0, 1, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_DIV,   SMIN,   1, ONES,   0, 1, 64'd0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_ADD,   SMAX,   1, 64'd1,  1, 1, SMIN,  1, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_LT,    ONES,   1, 64'd0,  1, 1, 64'd1, 1, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_LT,    ONES,   0, 64'd0,  1, 1, 64'd0, 1, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_SHL,   64'd1,  1, 64'd63, 0, 1, SMIN,  1, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_SHL,   64'd1,  0, 64'd64, 0, 1, 64'd0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_SHR,   SMIN,   1, ONES,   1, 1, ONES,  1, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_SHR,   SMIN,   0, ONES,   1, 1, 64'd0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_COMMA, 64'd9,  0, ONES,   1, 1, ONES,  1, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_LNOT,  64'd0,  0, ONES,   0, 1, 64'd1, 1, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_NOT,   64'd0,  0, 64'd0,  0, 1, ONES,  0, csua_pkg::ERR_NONE},
        '{5'd23,              ONES,   1, ONES,   1, 1, 64'd0, 0, csua_pkg::ERR_NONE},
        '{5'd31,              ONES,   1, ONES,   1, 1, 64'd0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_MUL,   ONES,   1, ONES,   1, 0, 0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_DIV,   -64'd7, 1, 64'd2,  1, 0, 0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_MOD,   -64'd7, 1, 64'd2,  1, 0, 0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_SUB,   64'd0,  0, 64'd1,  1, 0, 0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_SHR,   -64'd8, 1, 64'd1,  0, 0, 0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_GE,    SMIN,   1, SMAX,   1, 0, 0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_LAND,  ONES,   0, 64'd2,  0, 0, 0, 0, csua_pkg::ERR_NONE},
        '{csua_pkg::OP_NEG,   SMIN,   1, 64'd0,  0, 0, 0, 0, csua_pkg::ERR_NONE}
    };

    initial begin
        int phase;
        t_res typed;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_op(directed_rows[k].op, directed_rows[k].a, directed_rows[k].as,
                    directed_rows[k].b, directed_rows[k].bs);
            if (directed_rows[k].known) begin
                // Replace the prediction with the value typed into the row.
                typed.val = directed_rows[k].val;
                typed.rs = directed_rows[k].rs;
                typed.err = directed_rows[k].err;
                pending_results[pending_results.size() - 1] = typed;
            end
        end

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 77 : 34) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 77 : 34) : 0;
            repeat (212) begin
                send_op(5'($urandom_range(25) > 22 ? $urandom_range(31) : $urandom_range(22)),
                        rand_operand(), 1'($urandom), rand_operand(), 1'($urandom));
            end
        end
        i_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_c_signed_unsigned_integer_alu_core: done, clean");
        end else begin
            $display("tb_c_signed_unsigned_integer_alu_core: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/csua_pkg.sv
rtl/core/csua_front.sv
rtl/core/csua_queue.sv
rtl/core/csua_back.sv
rtl/core/c_signed_unsigned_integer_alu_core.sv
tb/tb_c_signed_unsigned_integer_alu_core.sv
